[sv/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, codes and constants shared by the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int VAL_W = 32;
	localparam int DIG_N = 10;
	localparam int BCD_W = 4 * DIG_N;
	localparam int CNT_W = 4;
	localparam int SHC_W = $clog2(VAL_W);

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_A     = 7'h41;

	localparam logic [CNT_W-1:0] CNT_SDEC = CNT_W'(DIG_N);
	localparam logic [CNT_W-1:0] CNT_FDEC = CNT_W'(4);
	localparam logic [CNT_W-1:0] CNT_HEX  = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_BIN  = CNT_W'(8);

	typedef enum logic [1:0] {
		MODE_SDEC = 2'd0,
		MODE_FDEC = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_BIN  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic signed [31:0] value;
	} request_t;

	typedef struct packed {
		logic [6:0] text_char;
		logic       last_char;
	} result_t;

	// digit string handed to the serializer, first digit in the top nibble
	typedef struct packed {
		logic [BCD_W-1:0] digits;
		logic [CNT_W-1:0] count;
		logic             skip;
		logic             minus;
	} emit_ld_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {3'b000, nib};
		end else begin
			c = CH_A + {3'b000, nib - 4'd10};
		end
		return c;
	endfunction

endpackage

[sv/i2a_dabble.sv]
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial binary to BCD conversion, shift and add-3, one bit per cycle.
// ----------------------------------------------------------------------------
module i2a_dabble (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [i2a_pkg::VAL_W-1:0] bin,
	output logic                      done,
	output logic [i2a_pkg::BCD_W-1:0] bcd
);
	import i2a_pkg::*;

	logic [VAL_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [SHC_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SHC_W'(VAL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VAL_W-1]};
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

[sv/i2a_emit.sv]
// ----------------------------------------------------------------------------
// i2a_emit
// Character serializer: shifts out one digit a cycle, optional leading minus,
// suppresses leading zeros when asked.
// ----------------------------------------------------------------------------
module i2a_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  i2a_pkg::emit_ld_t   ld,
	output logic                strobe,
	output i2a_pkg::result_t    result
);
	import i2a_pkg::*;

	logic [BCD_W-1:0] dig_q;
	logic [CNT_W-1:0] cnt_q;
	logic             skip_q;
	logic             minus_q;
	logic             act_q;
	logic             strobe_q;
	result_t          result_q;
	logic [3:0]       top;

	assign top = dig_q[BCD_W-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			strobe_q <= 1'b0;
			cnt_q    <= '0;
			skip_q   <= 1'b0;
			minus_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (load) begin
				act_q   <= 1'b1;
				cnt_q   <= ld.count;
				skip_q  <= ld.skip;
				minus_q <= ld.minus;
			end else if (act_q) begin
				if (minus_q) begin
					strobe_q <= 1'b1;
					minus_q  <= 1'b0;
				end else if (skip_q && top == 4'd0 && cnt_q > CNT_W'(1)) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					strobe_q <= 1'b1;
					skip_q   <= 1'b0;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						act_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= ld.digits;
		end else if (act_q) begin
			if (minus_q) begin
				result_q.text_char <= CH_MINUS;
				result_q.last_char <= 1'b0;
			end else begin
				result_q.text_char <= hex_char(top);
				result_q.last_char <= (cnt_q == CNT_W'(1));
				dig_q              <= {dig_q[BCD_W-5:0], 4'd0};
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

[sv/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer as ASCII text, one character per strobe, last flagged.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the cycle after the last character. Characters appear on result one per
// cycle, apart from pauses while suppressed leading zeros are skipped, each
// valid for exactly one cycle with strobe high; the receiver cannot stall, so
// it must take every strobe. Both decimal modes run the value through a
// one-bit-per-cycle shift and add-3 converter, then the serializer walks all
// ten digit slots in signed mode, staying silent on each leading zero. Hex
// and binary skip the converter. The next item can be taken in the cycle
// after the last character.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  i2a_pkg::request_t request,
	output logic              busy,
	output logic              strobe,
	output i2a_pkg::result_t  result
);
	import i2a_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic             mode_sdec_q;
	logic             neg_q;
	logic             accept;
	logic             is_dec;
	logic [VAL_W-1:0] dab_in;
	logic             dab_done;
	logic [BCD_W-1:0] bcd;
	logic             emit_load;
	emit_ld_t         emit_ld;
	logic [7:0]       lo8;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign is_dec = (request.req_type == MODE_SDEC) || (request.req_type == MODE_FDEC);
	assign lo8    = request.value[7:0];

	always_comb begin
		if (request.req_type == MODE_SDEC) begin
			dab_in = request.value[VAL_W-1] ? (VAL_W'(0) - request.value) : request.value;
		end else begin
			dab_in = {16'd0, request.value[15:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_sdec_q <= (request.req_type == MODE_SDEC);
			neg_q       <= request.value[VAL_W-1];
		end
	end

	always_comb begin
		state_d   = state_q;
		emit_load = 1'b0;
		emit_ld   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (is_dec) begin
						state_d = ST_CONV;
					end else begin
						state_d   = ST_EMIT;
						emit_load = 1'b1;
						if (request.req_type == MODE_HEX) begin
							emit_ld.digits = {lo8, (BCD_W-8)'(0)};
							emit_ld.count  = CNT_HEX;
						end else begin
							emit_ld.digits = {3'b000, lo8[7], 3'b000, lo8[6],
								3'b000, lo8[5], 3'b000, lo8[4], 3'b000, lo8[3],
								3'b000, lo8[2], 3'b000, lo8[1], 3'b000, lo8[0],
								(BCD_W-32)'(0)};
							emit_ld.count  = CNT_BIN;
						end
					end
				end
			end
			ST_CONV: begin
				if (dab_done) begin
					state_d   = ST_EMIT;
					emit_load = 1'b1;
					if (mode_sdec_q) begin
						emit_ld.digits = bcd;
						emit_ld.count  = CNT_SDEC;
						emit_ld.skip   = 1'b1;
						emit_ld.minus  = neg_q;
					end else begin
						emit_ld.digits = {bcd[15:0], (BCD_W-16)'(0)};
						emit_ld.count  = CNT_FDEC;
					end
				end
			end
			ST_EMIT: begin
				if (strobe && result.last_char) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	i2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && is_dec),
		.bin    (dab_in),
		.done   (dab_done),
		.bcd    (bcd)
	);

	i2a_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit_load),
		.ld     (emit_ld),
		.strobe (strobe),
		.result (result)
	);

endmodule

[verif/i2a_text_monitor.sv]
// ----------------------------------------------------------------------------
// i2a_text_monitor
// Predicts the ASCII text of each accepted item and checks every strobed
// character against it, in order, field by field.
// ----------------------------------------------------------------------------
module i2a_text_monitor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  i2a_pkg::request_t request,
	input  logic              strobe,
	input  i2a_pkg::result_t  result,
	output int                fail_count,
	output int                pending
);
	import i2a_pkg::*;

	result_t expected_text[$];
	int mismatches = 0;

	// expected characters of one request, last one flagged
	function automatic void format_text(input request_t r);
		logic [6:0]  txt [11];
		logic [6:0]  digs [10];
		logic [31:0] raw;
		logic [31:0] mag;
		logic [31:0] v;
		logic [3:0]  nib;
		result_t     ch;
		int          n;
		int          nd;
		raw = r.value;
		n = 0;
		case (mode_t'(r.req_type))
			MODE_SDEC: begin
				if (raw == 32'd0) begin
					txt[0] = CH_ZERO;
					n = 1;
				end else begin
					if (raw[31]) begin
						mag = 32'd0 - raw;
						txt[n] = CH_MINUS;
						n++;
					end else begin
						mag = raw;
					end
					nd = 0;
					while (mag != 32'd0) begin
						digs[nd] = CH_ZERO + 7'(mag % 32'd10);
						mag = mag / 32'd10;
						nd++;
					end
					while (nd > 0) begin
						nd--;
						txt[n] = digs[nd];
						n++;
					end
				end
			end
			MODE_FDEC: begin
				v = {16'd0, raw[15:0]} % 32'd10000;
				txt[0] = CH_ZERO + 7'(v / 32'd1000);
				txt[1] = CH_ZERO + 7'((v % 32'd1000) / 32'd100);
				txt[2] = CH_ZERO + 7'((v % 32'd100) / 32'd10);
				txt[3] = CH_ZERO + 7'(v % 32'd10);
				n = 4;
			end
			MODE_HEX: begin
				for (int k = 0; k < 2; k++) begin
					nib = (k == 0) ? raw[7:4] : raw[3:0];
					txt[k] = (nib < 4'd10) ? CH_ZERO + 7'(nib) : CH_A + 7'(nib - 4'd10);
				end
				n = 2;
			end
			default: begin
				for (int b = 0; b < 8; b++) begin
					txt[b] = CH_ZERO + 7'(raw[7-b]);
				end
				n = 8;
			end
		endcase
		for (int k = 0; k < n; k++) begin
			ch.text_char = txt[k];
			ch.last_char = (k == n - 1);
			expected_text.push_back(ch);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				format_text(request);
			end
			if (strobe) begin
				if (expected_text.size() == 0) begin
					$error("unexpected character: text_char %h last_char %b",
						result.text_char, result.last_char);
					mismatches++;
				end else begin
					want = expected_text.pop_front();
					if (result.text_char !== want.text_char) begin
						$error("text_char: expected %h, got %h",
							want.text_char, result.text_char);
						mismatches++;
					end
					if (result.last_char !== want.last_char) begin
						$error("last_char: expected %b, got %b",
							want.last_char, result.last_char);
						mismatches++;
					end
				end
			end
		end
		fail_count <= mismatches;
		pending <= expected_text.size();
	end

endmodule

[verif/integer_to_ascii_formatter_tb.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Drives directed and random format requests through the formatter under
// several sender idle rates; a monitor checks every character produced.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
	import i2a_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	request_t request;
	logic     busy;
	logic     strobe;
	result_t  result;
	int       fail_count;
	int       pending;

	request_t directed_reqs [22] = '{
		'{MODE_SDEC, 32'h0000_0000}, '{MODE_SDEC, 32'h0000_0001},
		'{MODE_SDEC, 32'hFFFF_FFFF}, '{MODE_SDEC, 32'h7FFF_FFFF},
		'{MODE_SDEC, 32'h8000_0000}, '{MODE_SDEC, 32'h0000_000A},
		'{MODE_SDEC, 32'hFFFF_FFF6}, '{MODE_SDEC, 32'd1000000000},
		'{MODE_SDEC, 32'h0000_0009},
		'{MODE_FDEC, 32'h0000_0000}, '{MODE_FDEC, 32'd9999},
		'{MODE_FDEC, 32'd10000},     '{MODE_FDEC, 32'd65535},
		'{MODE_FDEC, 32'hFFFF_0000}, '{MODE_FDEC, 32'h0001_04D2},
		'{MODE_HEX,  32'h0000_0000}, '{MODE_HEX,  32'h0000_00FF},
		'{MODE_HEX,  32'h1234_56AB}, '{MODE_HEX,  32'h0000_003C},
		'{MODE_BIN,  32'h0000_0000}, '{MODE_BIN,  32'h0000_00FF},
		'{MODE_BIN,  32'hFFFF_FF5A}
	};

	int idle_pct [4] = '{0, 75, 0, 25};

	always #5 clk = ~clk;

	integer_to_ascii_formatter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.strobe  (strobe),
		.result  (result)
	);

	i2a_text_monitor text_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.strobe     (strobe),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// returns at the edge that accepts the item
	task automatic send_item(input request_t r);
		request <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic sender_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			request <= {2'($urandom_range(3)), 32'($urandom)};
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 60)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	endtask

	initial begin
		request_t r;
		logic [31:0] v;
		int guard;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_reqs[i]) begin
			send_item(directed_reqs[i]);
		end

		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 40; i++) begin
				sender_gap(idle_pct[ph]);
				case ($urandom_range(5))
					0, 1: v = $urandom;
					2: v = $urandom >> $urandom_range(31);
					3: v = 32'd0 - ($urandom >> $urandom_range(31));
					4: v = $urandom_range(99999);
					default: begin
						case ($urandom_range(4))
							0: v = 32'h8000_0000;
							1: v = 32'h7FFF_FFFF;
							2: v = 32'h0000_0000;
							3: v = 32'hFFFF_FFFF;
							default: v = 32'd10000 + $urandom_range(55535);
						endcase
					end
				endcase
				r.req_type = 2'($urandom_range(3));
				r.value = v;
				send_item(r);
			end
		end
		start <= 1'b0;

		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending != 0 && guard < 1000);
		repeat (60) @(posedge clk);
		if (pending != 0) begin
			$error("%0d expected characters never arrived", pending);
		end
		if (fail_count == 0 && pending == 0) begin
			$display("PASS integer_to_ascii_formatter");
		end else begin
			$display("FAIL integer_to_ascii_formatter");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL integer_to_ascii_formatter");
		$finish;
	end

endmodule

[integer_to_ascii_formatter.f]
sv/i2a_pkg.sv
sv/i2a_dabble.sv
sv/i2a_emit.sv
sv/integer_to_ascii_formatter.sv
verif/i2a_text_monitor.sv
verif/integer_to_ascii_formatter_tb.sv
